>>> hw/rtl/utf8_decoder_raw_byte_escape_core_assert.svh
// Assertion macros for the UTF-8 raw-byte escape decoder checker
`ifndef UTF8_DECODER_RAW_BYTE_ESCAPE_CORE_ASSERT_SVH
`define UTF8_DECODER_RAW_BYTE_ESCAPE_CORE_ASSERT_SVH

// same-cycle implication
`define U8ESC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8esc: check failed");

// next-cycle implication
`define U8ESC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8esc: check failed");

`endif

>>> hw/rtl/u8esc_pkg.sv
// Shared types, constants and the sequence decode function of the UTF-8 escape decoder
package u8esc_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] ESC_BASE    = 21'h00DC00;
    localparam logic [CP_W-1:0] LEAST_2     = 21'h000080;
    localparam logic [CP_W-1:0] LEAST_3     = 21'h000800;
    localparam logic [CP_W-1:0] LEAST_4     = 21'h010000;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic last;
    } stat_t;

    typedef struct packed {
        logic            emit;
        logic [2:0]      adv;
        logic [CP_W-1:0] cp;
        logic            esc;
    } dec_t;

    function automatic dec_t u8_decode(input logic [31:0] win, input logic [2:0] avail,
                                       input logic eot);
        dec_t            r;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [7:0]      b3;
        logic [2:0]      len;
        logic [2:0]      lim;
        logic            bad;
        logic [CP_W-1:0] c;
        logic [CP_W-1:0] least;
        b0 = win[7:0];
        b1 = win[15:8];
        b2 = win[23:16];
        b3 = win[31:24];
        if ((b0 & LEAD2_MASK) == LEAD2_CODE) begin
            len   = 3'd2;
            c     = {10'd0, b0[4:0], b1[5:0]};
            least = LEAST_2;
        end else if ((b0 & LEAD3_MASK) == LEAD3_CODE) begin
            len   = 3'd3;
            c     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            least = LEAST_3;
        end else if ((b0 & LEAD4_MASK) == LEAD4_CODE) begin
            len   = 3'd4;
            c     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            least = LEAST_4;
        end else begin
            len   = 3'd0;
            c     = '0;
            least = '0;
        end
        lim = (avail < len) ? avail : len;
        bad = 1'b0;
        if (lim > 3'd1 && b1[7:6] != CONT_TAG) bad = 1'b1;
        if (lim > 3'd2 && b2[7:6] != CONT_TAG) bad = 1'b1;
        if (lim > 3'd3 && b3[7:6] != CONT_TAG) bad = 1'b1;
        r.emit = 1'b1;
        r.adv  = 3'd1;
        r.cp   = ESC_BASE + CP_W'(b0);
        r.esc  = 1'b1;
        if (avail == 3'd0) begin
            r.emit = 1'b0;
        end else if (!b0[7]) begin
            r.cp  = CP_W'(b0);
            r.esc = 1'b0;
        end else if (len == 3'd0 || bad) begin
            r.esc = 1'b1;
        end else if (avail < len) begin
            r.emit = eot;
        end else if (!(c < least || c > CP_MAX || (c >= SURR_LO && c <= SURR_HI))) begin
            r.cp  = c;
            r.adv = len;
            r.esc = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/u8esc_dpath.sv
// Datapath: pending byte window, decode step with lookahead, result register
module u8esc_dpath
    import u8esc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  cmd_t            cmd,
    input  logic [7:0]      in_byte,
    input  logic            in_eot,
    output stat_t           stat,
    output logic [CP_W-1:0] cp_out,
    output logic            esc_out,
    output logic            last_out
);

    logic [31:0]     win_reg;
    logic [31:0]     win_next;
    logic [2:0]      cnt_reg;
    logic [2:0]      cnt_next;
    logic            eot_reg;
    logic [CP_W-1:0] cp_reg;
    logic            esc_reg;
    logic            last_reg;
    logic [31:0]     win_shift;
    logic [2:0]      cnt_left;
    dec_t            dec;
    dec_t            dec_ahead;

    always_comb begin
        dec = u8_decode(win_reg, cnt_reg, eot_reg);
        case (dec.adv)
            3'd1:    win_shift = {8'd0, win_reg[31:8]};
            3'd2:    win_shift = {16'd0, win_reg[31:16]};
            3'd3:    win_shift = {24'd0, win_reg[31:24]};
            default: win_shift = '0;
        endcase
        cnt_left  = cnt_reg - dec.adv;
        dec_ahead = u8_decode(win_shift, cnt_left, eot_reg);
        stat.emit = dec.emit;
        stat.last = !dec_ahead.emit;
    end

    always_comb begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            win_next[{cnt_reg[1:0], 3'b000} +: 8] = in_byte;
            cnt_next = cnt_reg + 3'd1;
        end else if (cmd.step && dec.emit) begin
            win_next = win_shift;
            cnt_next = cnt_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (cmd.load) begin
            eot_reg <= in_eot;
        end
        if (cmd.step && dec.emit) begin
            cp_reg   <= dec.cp;
            esc_reg  <= dec.esc;
            last_reg <= !dec_ahead.emit;
        end
    end

    assign cp_out   = cp_reg;
    assign esc_out  = esc_reg;
    assign last_out = last_reg;

endmodule

>>> hw/rtl/u8esc_ctrl.sv
// Controller: accept/run state machine and result word valid
module u8esc_ctrl
    import u8esc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.step   = (state_reg == ST_RUN) && (!out_valid_reg || m_tready);
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cmd.step && (!stat.emit || stat.last)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.step && stat.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> hw/rtl/utf8_decoder_raw_byte_escape_core.sv
// Top level of the UTF-8 decoder with raw-byte escape
// The decode step emits one result per cycle while m_tready does not stall the output,
// and a new byte is taken once the last result is registered.
// The result register lets a finished word wait while the next byte is accepted.
// Reset (aresetn low, synchronous) clears the pending count, state and m_tvalid.
module utf8_decoder_raw_byte_escape_core
    import u8esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tuser,   // is_escaped
    output logic        m_tlast    // last_in_run
);

    cmd_t            cmd;
    stat_t           stat;
    logic [CP_W-1:0] cp;

    u8esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    u8esc_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_byte  (s_tdata),
        .in_eot   (s_tlast),
        .stat     (stat),
        .cp_out   (cp),
        .esc_out  (m_tuser),
        .last_out (m_tlast)
    );

    assign m_tdata = {3'd0, cp};

endmodule

>>> hw/rtl/u8esc_checker.sv
// Port-level checker for the UTF-8 escape decoder, bound to the top level
`include "utf8_decoder_raw_byte_escape_core_assert.svh"
module u8esc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `U8ESC_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `U8ESC_ASSERT_NEXT(a_hold_word, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `U8ESC_ASSERT_NOW(a_esc_range, aclk, aresetn, m_tvalid && m_tuser, m_tdata[23:7] == 17'h001B9)
    `U8ESC_ASSERT_NOW(a_cp_legal, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[23:21] == 3'd0 && m_tdata[20:16] <= 5'h10 && m_tdata[20:11] != 10'h01B)
    `U8ESC_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind utf8_decoder_raw_byte_escape_core u8esc_checker u_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for the UTF-8 decoder with raw-byte escape
import u8esc_pkg::*;

module testbench;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 147;
    localparam int unsigned END_WAIT    = 16;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            esc;
        logic            last;
    } cp_word_t;

    class code_point_board;
        logic [7:0]  held[3];
        int unsigned held_n;
        cp_word_t    cp_due_q[$];
        int unsigned errors;

        function new();
            held_n = 0;
            errors = 0;
        endfunction

        function void due_word(logic [CP_W-1:0] cp, logic esc);
            cp_word_t w;
            w.cp   = cp;
            w.esc  = esc;
            w.last = 1'b0;
            cp_due_q.insert(cp_due_q.size(), w);
        endfunction

        function void decode_byte(logic [7:0] b, logic eot);
            logic [7:0]  win[4];
            logic [7:0]  b0;
            int unsigned n, pos, k, len, lim, avail, made;
            int unsigned acc, least;
            bit          ok, waiting;
            n = held_n;
            for (k = 0; k < n; k++) win[k] = held[k];
            win[n] = b;
            n++;
            pos = 0;
            made = 0;
            waiting = 1'b0;
            while (pos < n && !waiting) begin
                b0 = win[pos];
                avail = n - pos;
                if (!b0[7]) begin
                    due_word(CP_W'(b0), 1'b0);
                    made++;
                    pos++;
                end else begin
                    if ((b0 & LEAD2_MASK) == LEAD2_CODE) begin
                        len = 2; acc = b0[4:0]; least = LEAST_2;
                    end else if ((b0 & LEAD3_MASK) == LEAD3_CODE) begin
                        len = 3; acc = b0[3:0]; least = LEAST_3;
                    end else if ((b0 & LEAD4_MASK) == LEAD4_CODE) begin
                        len = 4; acc = b0[2:0]; least = LEAST_4;
                    end else begin
                        len = 0; acc = 0; least = 0;
                    end
                    ok = (len > 0);
                    lim = (avail < len) ? avail : len;
                    for (k = 1; ok && k < lim; k++) begin
                        if (win[pos+k][7:6] != CONT_TAG) ok = 1'b0;
                    end
                    if (ok && avail < len) begin
                        if (!eot) waiting = 1'b1;
                        else ok = 1'b0;
                    end
                    if (!waiting) begin
                        if (ok) begin
                            for (k = 1; k < len; k++) acc = (acc << 6) | win[pos+k][5:0];
                            if (acc < least || acc > CP_MAX ||
                                (acc >= SURR_LO && acc <= SURR_HI)) ok = 1'b0;
                        end
                        if (ok) begin
                            due_word(CP_W'(acc), 1'b0);
                            pos += len;
                        end else begin
                            due_word(ESC_BASE + CP_W'(b0), 1'b1);
                            pos++;
                        end
                        made++;
                    end
                end
            end
            held_n = n - pos;
            for (k = 0; k < held_n; k++) held[k] = win[pos+k];
            if (made > 0) cp_due_q[cp_due_q.size()-1].last = 1'b1;
        endfunction

        function void check_word(logic [CP_W-1:0] cp, logic esc, logic last);
            cp_word_t w;
            if (cp_due_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got cp=%h esc=%b last=%b",
                         $time, cp, esc, last);
                errors++;
                return;
            end
            w = cp_due_q.pop_front();
            if (w.cp !== cp) begin
                $display("%0t: code_point expected %h got %h", $time, w.cp, cp);
                errors++;
            end
            if (w.esc !== esc) begin
                $display("%0t: is_escaped expected %b got %b (cp %h)", $time, w.esc, esc, w.cp);
                errors++;
            end
            if (w.last !== last) begin
                $display("%0t: last_in_run expected %b got %b (cp %h)",
                         $time, w.last, last, w.cp);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    code_point_board board = new();
    int unsigned     send_idle_pct = 32;
    int unsigned     recv_idle_pct = 60;
    int unsigned     quiet_cycles  = 0;
    logic [7:0]      chunk_q[$];

    utf8_decoder_raw_byte_escape_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_word(m_tdata[CP_W-1:0], m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_chunk(input bit eot_last);
        foreach (chunk_q[i]) send_byte(chunk_q[i], eot_last && (i == chunk_q.size() - 1));
    endtask

    function automatic void add_byte(logic [7:0] b);
        chunk_q.insert(chunk_q.size(), b);
    endfunction

    function automatic void append_utf8(int unsigned cp, int unsigned len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({CONT_TAG, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({CONT_TAG, cp[11:6]});
                add_byte({CONT_TAG, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({CONT_TAG, cp[17:12]});
                add_byte({CONT_TAG, cp[11:6]});
                add_byte({CONT_TAG, cp[5:0]});
            end
        endcase
    endfunction

    function automatic int unsigned valid_cp(int unsigned len);
        int unsigned cp;
        case (len)
            1: cp = $urandom_range(32'h7F);
            2: cp = $urandom_range(32'h7FF, 32'h80);
            3: begin
                cp = $urandom_range(32'hFFFF, 32'h800);
                if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 32'h4000;
            end
            default: cp = $urandom_range(32'h10FFFF, 32'h10000);
        endcase
        return cp;
    endfunction

    // build one random run of bytes; mostly well-formed, the rest broken or noise
    task automatic make_chunk(output bit eot);
        int unsigned pick, len, idx;
        logic [7:0]  junk;
        chunk_q.delete();
        pick = $urandom_range(99);
        eot  = ($urandom_range(7) == 0);
        if (pick < 65) begin
            len = $urandom_range(4, 1);
            append_utf8(valid_cp(len), len);
        end else if (pick < 75) begin
            len = $urandom_range(4, 2);
            case (len)
                2: append_utf8($urandom_range(32'h7F), 2);
                3: append_utf8($urandom_range(32'h7FF), 3);
                default: append_utf8($urandom_range(32'hFFFF), 4);
            endcase
        end else if (pick < 80) begin
            if ($urandom_range(1)) append_utf8($urandom_range(SURR_HI, SURR_LO), 3);
            else append_utf8($urandom_range(32'h1FFFFF, 32'h110000), 4);
        end else if (pick < 90) begin
            len = $urandom_range(4, 2);
            append_utf8(valid_cp(len), len);
            if ($urandom_range(1)) begin
                repeat ($urandom_range(len - 1, 1)) chunk_q.delete(chunk_q.size() - 1);
                eot = 1'($urandom_range(1));
            end else begin
                idx = $urandom_range(len - 1, 1);
                do junk = 8'($urandom_range(255)); while (junk[7:6] == CONT_TAG);
                chunk_q[idx] = junk;
            end
        end else begin
            repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int unsigned sent;
        bit          eot_flag;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // plain ASCII at both ends
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
        // shortest two-byte, largest three- and four-byte forms
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // overlong, surrogate, above range with four escapes at once
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF5, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // early bad continuation, cut off at end, bad lead, end mark with nothing held
        send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 32; recv_idle_pct = 60; end
                1: begin send_idle_pct = 60; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                make_chunk(eot_flag);
                sent += chunk_q.size();
                send_chunk(eot_flag);
            end
        end
        s_tvalid <= 1'b0;

        while (board.cp_due_q.size() != 0) @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);
        if (board.errors == 0 && board.cp_due_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
